@@ hdl/fbcr_pkg.sv @@
// Shared types and constants for the five-byte command frame receiver.
package fbcr_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COMMAND = 2'd2;

    // Register reset values
    localparam logic [7:0] START_BYTE_RST  = 8'hEE;
    localparam logic [7:0] END_BYTE_RST    = 8'hFF;
    localparam logic [7:0] MAX_COMMAND_RST = 8'hFF;

    // Commands that take a sub code of 0..2; all others take only 0
    localparam logic [7:0] LOW_CMD_FIRST = 8'd1;
    localparam logic [7:0] LOW_CMD_LAST  = 8'd3;
    localparam logic [7:0] LOW_SUB_MAX   = 8'd2;

    // Frame queue between the assembler and the judge
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CMD_RANGE = 2'd1,
        ST_CHECK     = 2'd2,
        ST_SUB       = 2'd3
    } status_t;

    // One complete frame as captured by the assembler
    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] sub;
        logic [7:0] chk;
    } frame_t;

    // Queue fill flags seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

@@ hdl/fbcr_front.sv @@
// Frame assembler: hunts for the start byte and collects the frame bytes.
module fbcr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            start_byte,
    input  logic [7:0]            end_byte,
    input  fbcr_pkg::fifo_status_t q_stat,
    output logic                  push,
    output fbcr_pkg::frame_t      push_data
);
    import fbcr_pkg::*;

    typedef enum logic [2:0] {
        HUNT      = 3'd0,
        GOT_START = 3'd1,
        GOT_CMD   = 3'd2,
        GOT_SUB   = 3'd3,
        GOT_CHK   = 3'd4
    } pos_t;

    pos_t       pos_reg;
    logic [7:0] cmd_reg;
    logic [7:0] sub_reg;
    logic [7:0] chk_reg;
    logic       accept;
    logic       is_start;
    logic       is_end;

    // Take a byte whenever the queue has room for a frame
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign is_start = (rx_byte == start_byte);
    assign is_end   = (rx_byte == end_byte);

    // Hand a finished frame to the queue on a good end byte
    assign push           = accept && (pos_reg == GOT_CHK) && is_end;
    assign push_data.cmd  = cmd_reg;
    assign push_data.sub  = sub_reg;
    assign push_data.chk  = chk_reg;

    // Advance through the frame positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= HUNT;
            cmd_reg <= 8'd0;
            sub_reg <= 8'd0;
            chk_reg <= 8'd0;
        end
        else if (accept)
        begin
            unique case (pos_reg)
                GOT_START:
                begin
                    cmd_reg <= rx_byte;
                    pos_reg <= GOT_CMD;
                end
                GOT_CMD:
                begin
                    sub_reg <= rx_byte;
                    pos_reg <= GOT_SUB;
                end
                GOT_SUB:
                begin
                    chk_reg <= rx_byte;
                    pos_reg <= GOT_CHK;
                end
                GOT_CHK:
                begin
                    // a bad end byte may itself open the next frame
                    if (is_end)
                        pos_reg <= HUNT;
                    else
                        pos_reg <= is_start ? GOT_START : HUNT;
                end
                default:
                begin
                    pos_reg <= is_start ? GOT_START : HUNT;
                end
            endcase
        end
    end

endmodule

@@ hdl/fbcr_queue.sv @@
// Short frame queue between the assembler and the judge.
module fbcr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fbcr_pkg::frame_t       push_data,
    input  logic                   pop,
    output fbcr_pkg::frame_t       pop_data,
    output fbcr_pkg::fifo_status_t q_stat
);
    import fbcr_pkg::*;

    frame_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Store pushed frames
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

endmodule

@@ hdl/fbcr_back.sv @@
// Frame judge: checks a queued frame and holds the result for the output.
module fbcr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbcr_pkg::fifo_status_t q_stat,
    input  fbcr_pkg::frame_t       pop_data,
    output logic                   pop,
    input  logic [7:0]             start_byte,
    input  logic [7:0]             max_command,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [7:0]             command_id,
    output logic [7:0]             sub_code
);
    import fbcr_pkg::*;

    logic       valid_reg;
    status_t    status_reg;
    status_t    status_next;
    logic [7:0] cmd_reg;
    logic [7:0] sub_reg;
    logic       sub_ok;

    // Pull a frame when the output register is free or being emptied
    assign pop = !q_stat.empty && (!valid_reg || out_ready);

    // Judge the frame: first failing test wins
    always_comb
    begin
        if ((pop_data.cmd >= LOW_CMD_FIRST) && (pop_data.cmd <= LOW_CMD_LAST))
            sub_ok = (pop_data.sub <= LOW_SUB_MAX);
        else
            sub_ok = (pop_data.sub == 8'd0);

        priority if ((pop_data.cmd == 8'd0) || (pop_data.cmd > max_command))
            status_next = ST_CMD_RANGE;
        else if (pop_data.chk != (start_byte ^ pop_data.cmd ^ pop_data.sub))
            status_next = ST_CHECK;
        else if (!sub_ok)
            status_next = ST_SUB;
        else
            status_next = ST_OK;
    end

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            cmd_reg    <= pop_data.cmd;
            sub_reg    <= pop_data.sub;
        end
    end

    assign out_valid  = valid_reg;
    assign status     = status_reg;
    assign command_id = cmd_reg;
    assign sub_code   = sub_reg;

endmodule

@@ hdl/five_byte_command_frame_receiver_top.sv @@
// Top level of the five-byte command frame receiver.
// Takes one received byte per cycle on rx_byte while in_ready is high and assembles frames
// of start, command, sub code, check and end byte; each frame closed by a good end byte
// yields one item with a status and the command and sub code, offered on out_valid once
// the judge has moved it from the queue into the output register.
// A frame assembler feeds a two-entry frame queue that a judge drains into the output
// register, so bytes keep flowing while a result waits; in_ready is low whenever the queue
// holds two frames. Configuration writes take effect at once; the user must make them
// while the block is idle, which the block itself does not enforce.
module five_byte_command_frame_receiver_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [7:0]                     command_id,
    output logic [7:0]                     sub_code,
    input  logic                           cfg_write,
    input  logic [fbcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import fbcr_pkg::*;

    logic [7:0]   start_byte_reg;
    logic [7:0]   end_byte_reg;
    logic [7:0]   max_command_reg;
    fifo_status_t q_stat;
    logic         push;
    logic         pop;
    frame_t       push_data;
    frame_t       pop_data;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RST;
            end_byte_reg    <= END_BYTE_RST;
            max_command_reg <= MAX_COMMAND_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_BYTE:  start_byte_reg  <= cfg_data;
                REG_END_BYTE:    end_byte_reg    <= cfg_data;
                REG_MAX_COMMAND: max_command_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    fbcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .start_byte (start_byte_reg),
        .end_byte   (end_byte_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    fbcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    fbcr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .start_byte  (start_byte_reg),
        .max_command (max_command_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .command_id  (command_id),
        .sub_code    (sub_code)
    );

endmodule

@@ hdl/fbcr_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
module fbcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [7:0] command_id,
    input logic [7:0] sub_code
);
    import fbcr_pkg::*;

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(command_id) && $stable(sub_code))
        else $error("result item changed while stalled");

    // An accepted frame never carries command zero
    a_ok_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> (command_id != 8'd0))
        else $error("ok status with command zero");

    // Low commands take sub codes 0..2
    a_ok_low_sub: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) && (command_id <= LOW_CMD_LAST)
            |-> (sub_code <= LOW_SUB_MAX))
        else $error("ok status with bad sub code for low command");

    // Other commands take sub code 0 only
    a_ok_high_sub: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) && (command_id > LOW_CMD_LAST)
            |-> (sub_code == 8'd0))
        else $error("ok status with nonzero sub code");

endmodule

bind five_byte_command_frame_receiver_top fbcr_checker u_fbcr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .command_id (command_id),
    .sub_code   (sub_code)
);
